/* design/qtlv_pkg.sv */
// ----------------------------------------------------------------------------
// qtlv_pkg
// Types and constants shared by the response TLV result scanner.
// ----------------------------------------------------------------------------
package qtlv_pkg;

  localparam int unsigned SEEN_W = 5;

  localparam logic [SEEN_W-1:0] HEADER_BYTES    = 5'd13;
  localparam logic [SEEN_W-1:0] MIN_FRAME_BYTES = 5'd20;  // 4 + 9 + 7
  localparam logic [7:0]        RESULT_TYPE     = 8'h02;
  localparam logic [15:0]       RESULT_MIN_LEN  = 16'd4;

  localparam logic [2:0] IDX_SKIP = 3'd7;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_VALUE  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_word;
    logic [15:0] error_word;
  } result_item_t;

endpackage

/* design/qtlv_if.sv */
// ----------------------------------------------------------------------------
// qtlv channel interfaces
// Valid/ready channels for frame bytes in and result items out.
// ----------------------------------------------------------------------------
interface qtlv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface qtlv_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] result_word;
  logic [15:0] error_word;

  modport source (output valid, output status, output result_word, output error_word,
                  input ready);
  modport sink   (input valid, input status, input result_word, input error_word,
                  output ready);
endinterface

/* design/qtlv_scan.sv */
// ----------------------------------------------------------------------------
// qtlv_scan
// Per-frame parser state: header skip, record walk, result capture, status.
// ----------------------------------------------------------------------------
module qtlv_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  qtlv_pkg::byte_item_t  item,
  output qtlv_pkg::result_item_t res
);
  import qtlv_pkg::*;

  logic [SEEN_W-1:0] bytes_seen, bytes_seen_next;
  phase_t            phase, phase_next;
  logic [7:0]        record_type, record_type_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [15:0]       left_dec;
  logic [15:0]       len_full;
  logic [2:0]        value_index, value_index_next;
  logic [15:0]       captured_result, captured_result_next;
  logic [15:0]       captured_error, captured_error_next;
  logic              found, found_next;

  always_comb begin
    bytes_seen_next      = (bytes_seen < MIN_FRAME_BYTES) ? bytes_seen + 1'b1 : bytes_seen;
    phase_next           = phase;
    record_type_next     = record_type;
    bytes_left_next      = bytes_left;
    value_index_next     = value_index;
    captured_result_next = captured_result;
    captured_error_next  = captured_error;
    found_next           = found;
    left_dec             = bytes_left - 16'd1;
    len_full             = {item.data_byte, bytes_left[7:0]};

    case (phase)
      PH_HEADER: begin
        if (bytes_seen_next >= HEADER_BYTES) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        record_type_next = item.data_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        bytes_left_next = {8'd0, item.data_byte};
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left_next = len_full;
        if (record_type == RESULT_TYPE && len_full >= RESULT_MIN_LEN) begin
          value_index_next = 3'd0;
        end else begin
          value_index_next = IDX_SKIP;
        end
        phase_next = (len_full == 16'd0) ? PH_TYPE : PH_VALUE;
      end
      PH_VALUE: begin
        case (value_index)
          3'd0: captured_result_next = captured_result | {8'd0, item.data_byte};
          3'd1: captured_result_next = captured_result | {item.data_byte, 8'd0};
          3'd2: captured_error_next  = captured_error  | {8'd0, item.data_byte};
          3'd3: captured_error_next  = captured_error  | {item.data_byte, 8'd0};
          default: ;
        endcase
        if (value_index < 3'd4) value_index_next = value_index + 3'd1;
        bytes_left_next = left_dec;
        if (left_dec == 16'd0) begin
          if (value_index != IDX_SKIP) begin
            found_next = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_TYPE;
          end
        end
      end
      default: ;
    endcase

    // Short frame wins over everything else.
    res.result_word = 16'd0;
    res.error_word  = 16'd0;
    if (bytes_seen_next < MIN_FRAME_BYTES) begin
      res.status = ST_SHORT;
    end else if (found_next) begin
      res.status      = ST_FOUND;
      res.result_word = captured_result_next;
      res.error_word  = captured_error_next;
    end else if (phase_next == PH_VALUE) begin
      res.status = ST_OVERRUN;
    end else begin
      res.status = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.frame_end)) begin
      bytes_seen      <= '0;
      phase           <= PH_HEADER;
      record_type     <= '0;
      bytes_left      <= '0;
      value_index     <= '0;
      captured_result <= '0;
      captured_error  <= '0;
      found           <= 1'b0;
    end else if (take) begin
      bytes_seen      <= bytes_seen_next;
      phase           <= phase_next;
      record_type     <= record_type_next;
      bytes_left      <= bytes_left_next;
      value_index     <= value_index_next;
      captured_result <= captured_result_next;
      captured_error  <= captured_error_next;
      found           <= found_next;
    end
  end

  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= MIN_FRAME_BYTES) else $error("bytes_seen past saturation");

  a_done_found: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> found) else $error("done phase without found record");

  a_value_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE) |-> (bytes_left != 16'd0)) else $error("value phase with no bytes left");

  a_header_seen: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEADER) |-> (bytes_seen >= HEADER_BYTES))
    else $error("left header skip too early");

endmodule

/* design/qtlv_out_reg.sv */
// ----------------------------------------------------------------------------
// qtlv_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module qtlv_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  qtlv_pkg::result_item_t res,
  output logic                   can_load,
  qtlv_result_if.source          result
);
  import qtlv_pkg::*;

  logic         out_valid;
  result_item_t out_item;

  assign can_load = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item <= res;
  end

  assign result.valid       = out_valid;
  assign result.status      = out_item.status;
  assign result.result_word = out_item.result_word;
  assign result.error_word  = out_item.error_word;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load) else $error("result overwritten before taken");

  a_status_words: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_FOUND) |->
      (out_item.result_word == 16'd0 && out_item.error_word == 16'd0))
    else $error("nonzero words on a not-found result");

  a_load_sets: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid) else $error("load did not set valid");

endmodule

/* design/qmi_result_tlv_parser_top.sv */
// ----------------------------------------------------------------------------
// qmi_result_tlv_parser_top
// Scans a response frame byte by byte for the result record and reports it.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | item
//  ---------+-----+------------------------------------------+------------------
//  frame    | in  | data_byte[7:0], frame_end                | one frame byte
//  result   | out | status[1:0], result_word, error_word     | one per frame end
//
//  One byte per cycle while no last byte waits on a full result register. A byte
//  is held in the input register; the parser state updates as it leaves, and a
//  frame's result is registered in the result register as its last byte leaves.
//  Only a last byte waits on the result register; others move on while a result
//  stalls. rst is synchronous, high, and drops any partial frame.
// ----------------------------------------------------------------------------
module qmi_result_tlv_parser_top (
  input  logic          clk,
  input  logic          rst,
  qtlv_byte_if.sink     frame,
  qtlv_result_if.source result
);
  import qtlv_pkg::*;

  logic         in_valid;
  byte_item_t   in_item;
  logic         adv;
  logic         can_load;
  result_item_t res;

  // Stage advances unless it holds a last byte and the result register is full.
  assign adv         = in_valid && (!in_item.frame_end || can_load);
  assign frame.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_item.data_byte <= frame.data_byte;
      in_item.frame_end <= frame.frame_end;
    end
  end

  qtlv_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (adv),
    .item (in_item),
    .res  (res)
  );

  qtlv_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (adv && in_item.frame_end),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.frame_end && !can_load) |-> !frame.ready)
    else $error("last byte dropped while result register full");

  a_mid_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_item.frame_end) |-> frame.ready)
    else $error("non-final byte stalled");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (adv && in_item.frame_end) |=> result.valid)
    else $error("result missing after frame end");

endmodule

/* verif/qmi_result_tlv_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_result_tlv_parser_top_tb
// Feeds response frames byte by byte into the result record scanner: a short
// directed set of frames, then random frames that are mostly well formed.
// A local scanner predicts each frame's status and captured words, and every
// result item is checked field by field against it. Both channels stall at
// random, except for a stretch in the middle of the run.
// ----------------------------------------------------------------------------
module qmi_result_tlv_parser_top_tb;
  import qtlv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk;
  logic rst;

  qtlv_byte_if   frame_ch ();
  qtlv_result_if result_ch ();

  qmi_result_tlv_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_item_t   tx_bytes[$];
  result_item_t awaited_results[$];
  logic [7:0]   fbuf[$];

  int bytes_total;
  int bytes_taken;
  int errors;
  int quiet_cycles;

  // no idling on either side through this part of the run
  wire steady = (bytes_taken >= 600) && (bytes_taken < 900);

  // local copy of the scanner state
  logic [4:0]  seen_cnt;
  phase_t      scan_phase;
  logic [7:0]  rec_type;
  logic [15:0] remain;
  logic [2:0]  val_idx;
  logic [15:0] cap_result;
  logic [15:0] cap_error;
  logic        hit;

  task automatic clear_scan();
    seen_cnt   = '0;
    scan_phase = PH_HEADER;
    rec_type   = '0;
    remain     = '0;
    val_idx    = '0;
    cap_result = '0;
    cap_error  = '0;
    hit        = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    result_item_t r;
    if (seen_cnt < MIN_FRAME_BYTES) seen_cnt++;
    case (scan_phase)
      PH_HEADER: begin
        if (seen_cnt >= HEADER_BYTES) scan_phase = PH_TYPE;
      end
      PH_TYPE: begin
        rec_type   = b;
        scan_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        remain     = {8'h00, b};
        scan_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        remain[15:8] = b;
        val_idx = (rec_type == RESULT_TYPE && remain >= RESULT_MIN_LEN) ? 3'd0 : IDX_SKIP;
        scan_phase = (remain == 16'd0) ? PH_TYPE : PH_VALUE;
      end
      PH_VALUE: begin
        case (val_idx)
          3'd0: cap_result[7:0]  = b;
          3'd1: cap_result[15:8] = b;
          3'd2: cap_error[7:0]   = b;
          3'd3: cap_error[15:8]  = b;
          default: ;
        endcase
        if (val_idx < 3'd4) val_idx++;
        remain--;
        if (remain == 16'd0) begin
          if (val_idx != IDX_SKIP) begin
            hit        = 1'b1;
            scan_phase = PH_DONE;
          end else begin
            scan_phase = PH_TYPE;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      r = '0;
      if (seen_cnt < MIN_FRAME_BYTES) begin
        r.status = ST_SHORT;
      end else if (hit) begin
        r.status      = ST_FOUND;
        r.result_word = cap_result;
        r.error_word  = cap_error;
      end else if (scan_phase == PH_VALUE) begin
        r.status = ST_OVERRUN;
      end else begin
        r.status = ST_NONE;
      end
      awaited_results.push_back(r);
      clear_scan();
    end
  endtask

  // frame building
  task automatic add_rand(input int n);
    repeat (n) fbuf.push_back(8'($urandom));
  endtask

  task automatic add_rec_hdr(input logic [7:0] t, input logic [15:0] len);
    fbuf.push_back(t);
    fbuf.push_back(len[7:0]);
    fbuf.push_back(len[15:8]);
  endtask

  task automatic add_record(input logic [7:0] t, input logic [15:0] len);
    add_rec_hdr(t, len);
    add_rand(int'(len));
  endtask

  task automatic close_frame();
    foreach (fbuf[i])
      tx_bytes.push_back('{data_byte: fbuf[i], frame_end: (i == fbuf.size() - 1)});
    bytes_total += fbuf.size();
    fbuf.delete();
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 90) return 16'($urandom_range(1, 8));
    if (r < 97) return 16'($urandom_range(9, 20));
    return 16'($urandom_range(256, 300));
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.valid <= 1'b0;
    end else if (!frame_ch.valid || frame_ch.ready) begin
      if (tx_bytes.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
        frame_ch.valid     <= 1'b1;
        frame_ch.data_byte <= tx_bytes[0].data_byte;
        frame_ch.frame_end <= tx_bytes[0].frame_end;
        void'(tx_bytes.pop_front());
      end else begin
        frame_ch.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  // monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    result_item_t exp_r;
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready) begin
        scan_byte(frame_ch.data_byte, frame_ch.frame_end);
        bytes_taken++;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item: expected none, actual status %0d res %h err %h",
                   $time, result_ch.status, result_ch.result_word, result_ch.error_word);
        end else begin
          exp_r = awaited_results.pop_front();
          if (result_ch.status !== exp_r.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, result_ch.status);
          end
          if (result_ch.result_word !== exp_r.result_word) begin
            errors++;
            $display("%0t: result_word mismatch: expected %h actual %h",
                     $time, exp_r.result_word, result_ch.result_word);
          end
          if (result_ch.error_word !== exp_r.error_word) begin
            errors++;
            $display("%0t: error_word mismatch: expected %h actual %h",
                     $time, exp_r.error_word, result_ch.error_word);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("qmi_result_tlv_parser_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int kind;
    int nrec;
    int ending;
    logic [15:0] len;
    logic [7:0] t;

    clk                = 1'b0;
    rst                = 1'b1;
    frame_ch.valid     = 1'b0;
    frame_ch.data_byte = '0;
    frame_ch.frame_end = 1'b0;
    result_ch.ready    = 1'b0;
    bytes_total        = 0;
    bytes_taken        = 0;
    errors             = 0;
    quiet_cycles       = 0;
    clear_scan();

    // single-byte frame
    fbuf.push_back(8'hFF);
    close_frame();
    // 19 bytes with a complete result header: short wins over overrun
    add_rand(13); add_rec_hdr(RESULT_TYPE, 16'd4); add_rand(3);
    close_frame();
    // minimum frame, found, all ones
    repeat (13) fbuf.push_back(8'hFF);
    add_rec_hdr(RESULT_TYPE, 16'd4);
    repeat (4) fbuf.push_back(8'hFF);
    close_frame();
    // found with zero words; a second result record afterwards is ignored
    repeat (13) fbuf.push_back(8'h00);
    add_rec_hdr(RESULT_TYPE, 16'd4);
    repeat (4) fbuf.push_back(8'h00);
    add_record(RESULT_TYPE, 16'd4); add_rand(3);
    close_frame();
    // overrun, largest length
    add_rand(13); add_rec_hdr(RESULT_TYPE, 16'hFFFF); add_rand(6);
    close_frame();
    // two trailing header bytes are ignored
    add_rand(13); add_record(8'h05, 16'd2); add_record(8'h11, 16'd0);
    fbuf.push_back(RESULT_TYPE); fbuf.push_back(8'h04);
    close_frame();
    // one trailing header byte
    add_rand(13); add_record(8'hFE, 16'd4); fbuf.push_back(RESULT_TYPE);
    close_frame();
    // zero-length records, result type among them, then a found record
    add_rand(13); add_rec_hdr(8'h00, 16'd0); add_rec_hdr(RESULT_TYPE, 16'd0);
    add_rec_hdr(8'hFF, 16'd0); add_record(RESULT_TYPE, 16'd4);
    close_frame();
    // result type with short lengths skipped, then found with length 6
    add_rand(13); add_record(RESULT_TYPE, 16'd3); add_record(RESULT_TYPE, 16'd1);
    add_record(RESULT_TYPE, 16'd6);
    close_frame();
    // no result record, ends on a record boundary
    add_rand(13); add_record(8'h01, 16'd10);
    close_frame();
    // found, then a stray header byte
    add_rand(13); add_record(RESULT_TYPE, 16'd5); fbuf.push_back(8'h03);
    close_frame();
    // long result record with nonzero length high byte
    add_rand(13); add_record(RESULT_TYPE, 16'h0104);
    close_frame();
    // overrun on a record of another type
    add_rand(13); add_rec_hdr(8'h07, 16'd9); add_rand(8);
    close_frame();

    while (bytes_total < 1300) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        add_rand($urandom_range(1, 19));
      end else if (kind < 16) begin
        add_rand($urandom_range(20, 40));
      end else begin
        add_rand(13);
        nrec = $urandom_range(1, 4);
        for (int r = 0; r < nrec || fbuf.size() < 17; r++) begin
          t = ($urandom_range(99) < 45) ? RESULT_TYPE : 8'($urandom);
          len = pick_len();
          add_record(t, len);
        end
        ending = $urandom_range(99);
        if (ending < 20) begin
          len = 16'($urandom_range(1, 12));
          t = ($urandom_range(1) != 0) ? RESULT_TYPE : 8'($urandom);
          add_rec_hdr(t, len);
          add_rand($urandom_range(0, int'(len) - 1));
        end else if (ending < 35) begin
          add_rand($urandom_range(1, 2));
        end
      end
      close_frame();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (bytes_taken == bytes_total);
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("qmi_result_tlv_parser_top regression: pass");
    end else begin
      $display("qmi_result_tlv_parser_top regression: fail");
    end
    $finish;
  end

endmodule
